/* sv/two_pool_earliest_ready_matcher_defines.svh */
// assertion macros shared by the checker
`ifndef TWO_POOL_EARLIEST_READY_MATCHER_DEFINES_SVH
`define TWO_POOL_EARLIEST_READY_MATCHER_DEFINES_SVH

// same-cycle implication, ignored during reset
`define TPM_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tpm check failed");

// next-cycle implication, ignored during reset
`define TPM_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tpm check failed");

// next-cycle implication that also holds across reset
`define TPM_ASSERT_NEXT_ALWAYS(name, ante, cons) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("tpm check failed");

`endif

/* sv/tpm_pkg.sv */
// types and constants for the two-pool matcher
`timescale 1ns / 1ps
`default_nettype none
package tpm_pkg;

  localparam int TIME_W     = 11;
  localparam int READY_W    = 12;
  localparam int CNT_W      = 8;
  localparam int IN_DATA_W  = 24;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 24;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan_rd;
    logic last_rd;
    logic move_wr;
    logic new_unit;
    logic insert;
    logic result;
  } tpm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pool_empty;
    logic scan_last;
    logic reusable;
    logic out_free;
  } tpm_status_t;

endpackage
`default_nettype wire

/* sv/two_pool_earliest_ready_matcher.sv */
// top level of the two-pool earliest-ready unit matcher
//
//  channel  dir  signals                         contents
//  s_axis   in   tvalid tready tdata[23:0]       depart_time, arrive_time
//                tuser[1:0]                      start_case, origin_site
//  m_axis   out  tvalid tready tdata[23:0]       new_unit, units_site_a/b, pool_overflow
//  cfg      in   cfg_we cfg_wdata[10:0]          turnaround
//
// a trip loads, scans the origin pool, removes a reusable unit, inserts, reports; an empty
// origin pool skips the scan. the scan reads the shared ram port once per cycle.
// rst is synchronous; it clears fill counts, unit counts, turnaround and the output.
// the result waits in the output register; a stalled result holds the next trip at DONE.
`timescale 1ns / 1ps
`default_nettype none
module two_pool_earliest_ready_matcher #(
  parameter int POOL_DEPTH = 128
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [tpm_pkg::TIME_W-1:0]     cfg_wdata,     // turnaround
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // depart_time [10:0], arrive_time [21:11], zero pad [23:22]
  input  wire logic [tpm_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // start_case [0], origin_site [1]
  input  wire logic [tpm_pkg::IN_USER_W-1:0]  s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // new_unit [0], units_site_a [8:1], units_site_b [16:9], pool_overflow [17], zero [23:18]
  output logic      [tpm_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import tpm_pkg::*;

  tpm_cmd_t    cmd;
  tpm_status_t status;

  tpm_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .status       (status),
    .cmd          (cmd)
  );

  tpm_datapath #(
    .POOL_DEPTH(POOL_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

endmodule
`default_nettype wire

/* sv/tpm_ram.sv */
// generic single-write, single-read ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module tpm_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* sv/tpm_datapath.sv */
// pools, minimum search, counts and result register
`timescale 1ns / 1ps
`default_nettype none
module tpm_datapath #(
  parameter int POOL_DEPTH = 128
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire tpm_pkg::tpm_cmd_t              cmd,
  output tpm_pkg::tpm_status_t                status,
  input  wire logic                           cfg_we,
  input  wire logic [tpm_pkg::TIME_W-1:0]     cfg_wdata,
  input  wire logic [tpm_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  wire logic [tpm_pkg::IN_USER_W-1:0]  s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic      [tpm_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import tpm_pkg::*;

  localparam int IDX_W  = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int FILL_W = $clog2(POOL_DEPTH + 1);
  localparam int ADDR_W = IDX_W + 1;
  localparam int RAM_DEPTH = 2 ** ADDR_W;

  logic [TIME_W-1:0]  turnaround;
  logic [TIME_W-1:0]  depart;
  logic [TIME_W-1:0]  arrive;
  logic               site;
  logic [FILL_W-1:0]  fill [2];
  logic [CNT_W-1:0]   started [2];
  logic [IDX_W-1:0]   scan_idx;
  logic [IDX_W-1:0]   pend_idx;
  logic               scan_pend;
  logic [READY_W-1:0] best;
  logic [IDX_W-1:0]   where_idx;
  logic               fresh;
  logic               over;

  logic               dst;
  logic [FILL_W-1:0]  fill_org;
  logic [FILL_W-1:0]  fill_dst;
  logic [FILL_W-1:0]  fill_dec;
  logic               full_dst;
  logic [READY_W-1:0] ready_sum;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [READY_W-1:0] ram_wdata;
  logic               ram_re;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [READY_W-1:0] ram_rdata;

  assign dst       = ~site;
  assign fill_org  = fill[site];
  assign fill_dst  = fill[dst];
  assign fill_dec  = fill_org - FILL_W'(1);
  assign full_dst  = (fill_dst >= FILL_W'(POOL_DEPTH));
  assign ready_sum = {1'b0, arrive} + {1'b0, turnaround};

  assign ram_re    = cmd.scan_rd | cmd.last_rd;
  assign ram_raddr = cmd.last_rd ? {site, fill_dec[IDX_W-1:0]} : {site, scan_idx};
  assign ram_we    = cmd.move_wr | (cmd.insert & ~full_dst);
  assign ram_waddr = cmd.move_wr ? {site, where_idx} : {dst, fill_dst[IDX_W-1:0]};
  assign ram_wdata = cmd.move_wr ? ram_rdata : ready_sum;

  assign status.pool_empty = (fill_org == '0);
  assign status.scan_last  = (FILL_W'(scan_idx) == fill_dec);
  assign status.reusable   = (best <= {1'b0, depart});
  assign status.out_free   = ~m_axis_tvalid | m_axis_tready;

  tpm_ram #(
    .WIDTH(READY_W),
    .DEPTH(RAM_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      turnaround    <= '0;
      fill[0]       <= '0;
      fill[1]       <= '0;
      started[0]    <= '0;
      started[1]    <= '0;
      scan_pend     <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        turnaround <= cfg_wdata;
      end
      scan_pend <= cmd.scan_rd;
      pend_idx  <= scan_idx;
      if (cmd.load) begin
        depart   <= s_axis_tdata[TIME_W-1:0];
        arrive   <= s_axis_tdata[2*TIME_W-1:TIME_W];
        site     <= s_axis_tuser[1];
        scan_idx <= '0;
        fresh    <= 1'b0;
        over     <= 1'b0;
        if (s_axis_tuser[0]) begin
          fill[0]    <= '0;
          fill[1]    <= '0;
          started[0] <= '0;
          started[1] <= '0;
        end
      end
      if (cmd.scan_rd) begin
        scan_idx <= scan_idx + IDX_W'(1);
      end
      // lowest slot wins on ties
      if (scan_pend && ((pend_idx == '0) || (ram_rdata < best))) begin
        best      <= ram_rdata;
        where_idx <= pend_idx;
      end
      if (cmd.move_wr) begin
        fill[site] <= fill_dec;
      end
      if (cmd.new_unit) begin
        fresh <= 1'b1;
        if (started[site] != CNT_MAX) begin
          started[site] <= started[site] + CNT_W'(1);
        end
      end
      if (cmd.insert) begin
        over <= full_dst;
        if (!full_dst) begin
          fill[dst] <= fill_dst + FILL_W'(1);
        end
      end
      if (cmd.result) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tdata  <= {6'b0, over, started[1], started[0], fresh};
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

/* sv/tpm_ctrl.sv */
// sequencer for one trip: load, scan, remove, insert, report
`timescale 1ns / 1ps
`default_nettype none
module tpm_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire tpm_pkg::tpm_status_t status,
  output tpm_pkg::tpm_cmd_t         cmd
);
  import tpm_pkg::*;

  typedef enum logic [2:0] {
    IDLE,
    CHECK,
    SCAN,
    SCAN_END,
    DECIDE,
    MOVE,
    INSERT,
    DONE
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      unique case (state)
        IDLE:     if (s_axis_tvalid) state <= CHECK;
        CHECK:    state <= status.pool_empty ? INSERT : SCAN;
        SCAN:     if (status.scan_last) state <= SCAN_END;
        SCAN_END: state <= DECIDE;
        DECIDE:   state <= status.reusable ? MOVE : INSERT;
        MOVE:     state <= INSERT;
        INSERT:   state <= DONE;
        DONE:     if (status.out_free) state <= IDLE;
        default:  state <= IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state == IDLE);

  always_comb begin
    cmd          = '0;
    cmd.load     = (state == IDLE) && s_axis_tvalid;
    cmd.scan_rd  = (state == SCAN);
    cmd.last_rd  = (state == DECIDE) && status.reusable;
    cmd.move_wr  = (state == MOVE);
    // no reusable unit: empty pool, or earliest ready time after departure
    cmd.new_unit = ((state == CHECK) && status.pool_empty) ||
                   ((state == DECIDE) && !status.reusable);
    cmd.insert   = (state == INSERT);
    cmd.result   = (state == DONE) && status.out_free;
  end

endmodule
`default_nettype wire

/* sv/tpm_checker.sv */
// port-level checks for the matcher, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "two_pool_earliest_ready_matcher_defines.svh"
module tpm_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           s_axis_tvalid,
  input wire logic                           s_axis_tready,
  input wire logic                           m_axis_tvalid,
  input wire logic                           m_axis_tready,
  input wire logic [tpm_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  // no result survives reset
  `TPM_ASSERT_NEXT_ALWAYS(a_reset_clears_out, rst, !m_axis_tvalid)
  // one trip at a time: no second transaction right after one
  `TPM_ASSERT_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  // pad bits of the result stay zero
  `TPM_ASSERT_IMPL(a_pad_zero, m_axis_tvalid, m_axis_tdata[23:18] == 6'b0)
  // stalled result holds
  `TPM_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata))

endmodule
`default_nettype wire

bind two_pool_earliest_ready_matcher tpm_checker u_tpm_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
